[hdl/bsd_pkg.sv]
// ----------------------------------------------------------------------------
// bsd_pkg: shared types and constants of the BMP stream decoder
// Item structs, status codes and fixed header byte positions.
// ----------------------------------------------------------------------------
package bsd_pkg;

  // Result status codes
  typedef enum logic [2:0] {
    ST_PIXEL     = 3'd0,
    ST_BAD_MAGIC = 3'd1,
    ST_BAD_DEPTH = 3'd2,
    ST_SHORT     = 3'd3,
    ST_BAD_SIZE  = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] pixel_color;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic        last_pixel;
  } out_item_t;

  // Header byte positions
  localparam logic [5:0] POS_OFFSET = 6'd10;
  localparam logic [5:0] POS_WIDTH  = 6'd18;
  localparam logic [5:0] POS_HEIGHT = 6'd22;
  localparam logic [5:0] POS_DEPTH  = 6'd28;
  localparam logic [5:0] POS_CHECK  = 6'd53;

  localparam logic [15:0] BMP_MAGIC    = 16'h4D42;
  localparam logic [15:0] DEPTH_24     = 16'd24;
  localparam logic [15:0] DEPTH_32     = 16'd32;
  localparam logic [31:0] MIN_OFFSET   = 32'd54;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

endpackage

[hdl/bsd_hdr.sv]
// ----------------------------------------------------------------------------
// bsd_hdr: header capture and check
// Assembles the little-endian header fields, judges them on the check byte
// and latches the image geometry used by the pixel stage.
// ----------------------------------------------------------------------------
module bsd_hdr #(
  parameter int MAX_DIM = 4096,
  parameter int DW      = 13,
  parameter int BW      = 15
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             we,
  input  logic             capture,
  input  logic [5:0]       pos,
  input  logic [7:0]       data_byte,
  output bsd_pkg::status_t err,
  output logic [31:0]      offset_o,
  output logic [DW-1:0]    width_o,
  output logic [DW-1:0]    mag_o,
  output logic [BW-1:0]    stride_o,
  output logic             bpp32_o,
  output logic             bottom_up_o
);
  import bsd_pkg::*;

  logic [15:0]   magic_r;
  logic [31:0]   offset_r;
  logic [31:0]   width_r;
  logic [31:0]   height_r;
  logic [15:0]   depth_r;
  logic [DW-1:0] width_o_r;
  logic [DW-1:0] mag_o_r;
  logic [BW-1:0] stride_o_r;
  logic          bpp32_o_r;
  logic          bottom_up_o_r;

  logic [5:0]  d_off;
  logic [5:0]  d_wid;
  logic [5:0]  d_hgt;
  logic [5:0]  d_dep;
  logic [31:0] mag;
  logic        is32;
  logic [BW:0] span;
  logic [BW:0] stride_full;

  assign d_off = pos - POS_OFFSET;
  assign d_wid = pos - POS_WIDTH;
  assign d_hgt = pos - POS_HEIGHT;
  assign d_dep = pos - POS_DEPTH;

  always_ff @(posedge clk) begin
    if (we) begin
      if (pos < 6'd2) begin
        magic_r[{pos[0], 3'b000} +: 8] <= data_byte;
      end else if (d_off < 6'd4) begin
        offset_r[{d_off[1:0], 3'b000} +: 8] <= data_byte;
      end else if (d_wid < 6'd4) begin
        width_r[{d_wid[1:0], 3'b000} +: 8] <= data_byte;
      end else if (d_hgt < 6'd4) begin
        height_r[{d_hgt[1:0], 3'b000} +: 8] <= data_byte;
      end else if (d_dep < 6'd2) begin
        depth_r[{d_dep[0], 3'b000} +: 8] <= data_byte;
      end
    end
  end

  assign mag  = height_r[31] ? (~height_r + 32'd1) : height_r;
  assign is32 = (depth_r == DEPTH_32);

  always_comb begin
    if (magic_r != BMP_MAGIC) begin
      err = ST_BAD_MAGIC;
    end else if (depth_r != DEPTH_24 && depth_r != DEPTH_32) begin
      err = ST_BAD_DEPTH;
    end else if (width_r == 32'd0 || width_r > 32'(MAX_DIM) || mag == 32'd0 ||
                 mag > 32'(MAX_DIM) || offset_r < MIN_OFFSET) begin
      err = ST_BAD_SIZE;
    end else begin
      err = ST_PIXEL;
    end
  end

  // Row stride: bytes per row rounded up to a multiple of four
  always_comb begin
    if (is32) begin
      span = (BW + 1)'({width_r[DW-1:0], 2'b00});
    end else begin
      span = (BW + 1)'(width_r[DW-1:0]) + (BW + 1)'({width_r[DW-1:0], 1'b0});
    end
    stride_full = (span + (BW + 1)'(3)) & ~((BW + 1)'(3));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_o_r     <= '0;
      mag_o_r       <= '0;
      stride_o_r    <= '0;
      bpp32_o_r     <= 1'b0;
      bottom_up_o_r <= 1'b0;
    end else if (capture) begin
      width_o_r     <= width_r[DW-1:0];
      mag_o_r       <= mag[DW-1:0];
      stride_o_r    <= stride_full[BW-1:0];
      bpp32_o_r     <= is32;
      bottom_up_o_r <= ~height_r[31];
    end
  end

  assign offset_o    = offset_r;
  assign width_o     = width_o_r;
  assign mag_o       = mag_o_r;
  assign stride_o    = stride_o_r;
  assign bpp32_o     = bpp32_o_r;
  assign bottom_up_o = bottom_up_o_r;

endmodule

[hdl/bsd_pix.sv]
// ----------------------------------------------------------------------------
// bsd_pix: pixel assembly
// Gathers BGR/BGRA bytes into ARGB, tracks column, row and padding, and
// applies the color key.
// ----------------------------------------------------------------------------
module bsd_pix #(
  parameter int DW = 13,
  parameter int BW = 15
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                en,
  input  logic [7:0]          data_byte,
  input  logic [23:0]         color_key,
  input  logic [DW-1:0]       width,
  input  logic [DW-1:0]       mag,
  input  logic [BW-1:0]       stride,
  input  logic                bpp32,
  input  logic                bottom_up,
  output logic                pix_v,
  output bsd_pkg::out_item_t  pix,
  output logic                done
);
  import bsd_pkg::*;

  logic [23:0]   gather_r, gather_nxt;
  logic [1:0]    k_r, k_nxt;
  logic [DW-1:0] col_r, col_nxt;
  logic [BW-1:0] bir_r, bir_nxt;
  logic [DW-1:0] row_r, row_nxt;

  logic          in_span;
  logic [1:0]    last_lane;
  logic [31:0]   color;
  logic [DW-1:0] y;
  logic          last;
  logic [BW-1:0] bir_inc;
  logic          row_end;
  logic [DW-1:0] row_inc;
  logic [31:0]   x_ext;
  logic [31:0]   y_ext;

  assign in_span   = (col_r < width);
  assign last_lane = bpp32 ? 2'd3 : 2'd2;
  assign pix_v     = en && in_span && (k_r == last_lane);
  assign y         = bottom_up ? (mag - DW'(1) - row_r) : row_r;
  assign last      = (col_r == width - DW'(1)) && (row_r == mag - DW'(1));
  assign bir_inc   = bir_r + BW'(1);
  assign row_end   = (bir_inc == stride);
  assign row_inc   = row_r + DW'(1);
  assign done      = en && ((pix_v && last) || (row_end && row_inc >= mag));

  always_comb begin
    color = bpp32 ? {data_byte, gather_r} : {ALPHA_OPAQUE, data_byte, gather_r[15:0]};
    if (color_key != 24'd0 && color[23:0] == color_key) begin
      color = 32'd0;
    end
    x_ext           = 32'(col_r);
    y_ext           = 32'(y);
    pix             = '0;
    pix.status      = ST_PIXEL;
    pix.pixel_color = color;
    pix.pixel_x     = x_ext[11:0];
    pix.pixel_y     = y_ext[11:0];
    pix.last_pixel  = last;
  end

  always_comb begin
    gather_nxt = gather_r;
    k_nxt      = k_r;
    col_nxt    = col_r;
    bir_nxt    = bir_r;
    row_nxt    = row_r;
    if (start) begin
      gather_nxt = '0;
      k_nxt      = '0;
      col_nxt    = '0;
      bir_nxt    = '0;
      row_nxt    = '0;
    end else if (en) begin
      if (in_span) begin
        if (k_r != 2'd3) begin
          gather_nxt[{k_r, 3'b000} +: 8] = data_byte;
        end
        if (k_r == last_lane) begin
          gather_nxt = '0;
          k_nxt      = '0;
          col_nxt    = col_r + DW'(1);
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end
      if (row_end) begin
        // wrap to the next file row
        bir_nxt = '0;
        row_nxt = row_inc;
        col_nxt = '0;
        k_nxt   = '0;
      end else begin
        bir_nxt = bir_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gather_r <= '0;
      k_r      <= '0;
      col_r    <= '0;
      bir_r    <= '0;
      row_r    <= '0;
    end else begin
      gather_r <= gather_nxt;
      k_r      <= k_nxt;
      col_r    <= col_nxt;
      bir_r    <= bir_nxt;
      row_r    <= row_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_pix_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    en |-> (bir_r < stride && col_r <= width && row_r < mag))
    else $error("pixel counters out of image bounds");
`endif

endmodule

[hdl/bsd_obuf.sv]
// ----------------------------------------------------------------------------
// bsd_obuf: result register with skid stage
// Holds results while the receiver stalls; stalls the input only when both
// entries are full.
// ----------------------------------------------------------------------------
module bsd_obuf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               res_v,
  input  bsd_pkg::out_item_t res,
  output logic               in_stall,
  output logic               out_valid,
  output bsd_pkg::out_item_t out_data,
  input  logic               out_stall
);
  import bsd_pkg::*;

  logic      out_v_r;
  logic      skid_v_r;
  out_item_t out_d_r;
  out_item_t skid_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || !out_stall) begin
      // output slot frees: drain skid first, else take the new result
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= res_v;
      end
    end else if (res_v) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || !out_stall) begin
      out_d_r <= skid_v_r ? skid_d_r : res;
    end else if (res_v) begin
      skid_d_r <= res;
    end
  end

  assign in_stall  = skid_v_r;
  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

`ifndef ASSERT_OFF
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry held while output register is empty");
`endif

endmodule

[hdl/bmp_stream_decoder_color_key_unit.sv]
// ----------------------------------------------------------------------------
// bmp_stream_decoder_color_key_unit: streaming 24/32 bpp BMP decoder
// Parses the header, skips to the pixel data and emits keyed ARGB pixels.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one file byte per item, end_of_file set on the final byte.
//   out_*  : zero or one result per byte: a pixel with its column and row
//            (row flipped for bottom-up images), or one error status.
//   cfg_*  : 24-bit color key; cfg_ready is always high. Write only while
//            no file is in flight. Zero disables keying.
// Timing:
//   One byte is accepted per cycle unless in_stall is high. Its result is
//   registered before out_valid shows it. The per-byte work is a single
//   register-to-register pass over the phase, counter and header registers.
// Stall:
//   A result register plus one skid entry sit at the output. The input keeps
//   flowing while the result register waits; in_stall rises only when the
//   skid entry is also occupied, and drops as soon as it drains.
// Reset:
//   rst_n (synchronous, active low) returns to the header phase, clears the
//   byte position and pixel counters, empties the output and zeroes the key.
// ----------------------------------------------------------------------------
module bmp_stream_decoder_color_key_unit #(
  parameter int MAX_DIM = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bsd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output bsd_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [23:0]        cfg_data
);
  import bsd_pkg::*;

  // coordinate and row-byte counter widths
  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int BW = $clog2(4 * MAX_DIM + 1);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_SKIP,
    PH_PIXELS,
    PH_DROP
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [31:0] bpos_r, bpos_nxt;
  logic [23:0] color_key_r;

  logic        acc;
  logic [31:0] bp_inc;
  logic        hdr_we;
  logic        hdr_cap;
  status_t     hdr_err;
  logic [31:0] offset;
  logic [DW-1:0] width;
  logic [DW-1:0] mag;
  logic [BW-1:0] stride;
  logic        bpp32;
  logic        bottom_up;
  logic        pix_start;
  logic        pix_en;
  logic        pix_v;
  out_item_t   pix_item;
  logic        pix_done;
  logic        res_v;
  out_item_t   res;

  assign acc       = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign bp_inc    = bpos_r + 32'd1;
  assign hdr_we    = acc && (phase_r == PH_HEADER);
  assign hdr_cap   = hdr_we && (bpos_r == 32'(POS_CHECK));
  assign pix_start = hdr_cap && (hdr_err == ST_PIXEL);
  assign pix_en    = acc && (phase_r == PH_PIXELS);

  bsd_hdr #(
    .MAX_DIM (MAX_DIM),
    .DW      (DW),
    .BW      (BW)
  ) u_hdr (
    .clk         (clk),
    .rst_n       (rst_n),
    .we          (hdr_we),
    .capture     (hdr_cap),
    .pos         (bpos_r[5:0]),
    .data_byte   (in_data.data_byte),
    .err         (hdr_err),
    .offset_o    (offset),
    .width_o     (width),
    .mag_o       (mag),
    .stride_o    (stride),
    .bpp32_o     (bpp32),
    .bottom_up_o (bottom_up)
  );

  bsd_pix #(
    .DW (DW),
    .BW (BW)
  ) u_pix (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (pix_start),
    .en        (pix_en),
    .data_byte (in_data.data_byte),
    .color_key (color_key_r),
    .width     (width),
    .mag       (mag),
    .stride    (stride),
    .bpp32     (bpp32),
    .bottom_up (bottom_up),
    .pix_v     (pix_v),
    .pix       (pix_item),
    .done      (pix_done)
  );

  // Phase sequencing and result selection for the accepted byte
  always_comb begin
    phase_nxt  = phase_r;
    bpos_nxt   = bpos_r;
    res_v      = 1'b0;
    res        = '0;
    res.status = ST_PIXEL;
    if (acc) begin
      bpos_nxt = bp_inc;
      case (phase_r)
        PH_HEADER: begin
          if (hdr_cap) begin
            if (hdr_err != ST_PIXEL) begin
              res_v      = 1'b1;
              res.status = hdr_err;
              phase_nxt  = PH_DROP;
            end else begin
              phase_nxt = (offset == MIN_OFFSET) ? PH_PIXELS : PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
          // leave skip on the byte just before the pixel data
          if (bp_inc == offset) begin
            phase_nxt = PH_PIXELS;
          end
        end
        PH_PIXELS: begin
          if (pix_v) begin
            res_v = 1'b1;
            res   = pix_item;
          end
          if (pix_done) begin
            phase_nxt = PH_DROP;
          end
        end
        PH_DROP: begin
          phase_nxt = PH_DROP;
        end
        default: begin
          phase_nxt = PH_HEADER;
        end
      endcase
      // end of file: report a short file unless already done or in error, then rewind
      if (in_data.end_of_file) begin
        if (phase_nxt != PH_DROP) begin
          res_v      = 1'b1;
          res        = '0;
          res.status = ST_SHORT;
        end
        phase_nxt = PH_HEADER;
        bpos_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      bpos_r      <= '0;
      color_key_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      bpos_r  <= bpos_nxt;
      if (cfg_valid && cfg_ready) begin
        color_key_r <= cfg_data;
      end
    end
  end

  bsd_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_v     (res_v),
    .res       (res),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

`ifndef ASSERT_OFF
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_PIXEL) |->
      (out_data.pixel_color == 32'd0 && !out_data.last_pixel))
    else $error("error result carries pixel data");

  a_skip_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_SKIP) |-> (bpos_r < offset && offset > MIN_OFFSET))
    else $error("skip phase past the pixel data offset");
`endif

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for the streaming BMP decoder with color key
// Feeds whole and broken BMP files one byte per item, predicts every pixel
// and error status in a scoreboard, and checks each result in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bsd_pkg::*;

  localparam int          MAX_DIM       = 4096;
  localparam int          CLK_HALF      = 5;
  localparam int          RESET_CYCLES  = 7;
  localparam int          IDLE_PCT      = 21;
  localparam int          RAND_BYTES    = 500;
  // Results are registered behind their byte; give the skid path slack too.
  localparam int          SETTLE_CYCLES = 8;
  localparam int          HOLD_AT       = 100;
  localparam int          HOLD_CYCLES   = 400;
  localparam int          QUIET_FROM    = 600;
  localparam int          QUIET_TO      = 900;
  localparam int unsigned CYCLE_LIMIT   = 500000;
  localparam int          REPORT_MAX    = 10;

  // Decoder phases, tracked by the scoreboard alongside the block.
  typedef enum logic [1:0] {
    DP_HEADER,
    DP_SKIP,
    DP_PIXELS,
    DP_DROP
  } dec_phase_t;

  // --------------------------------------------------------------------------
  // Scoreboard: replays each accepted byte through its own decoder state and
  // queues the pixel or status that byte must produce.
  // --------------------------------------------------------------------------
  class bmp_pixel_board;
    logic [23:0] color_key;
    dec_phase_t  phase;
    logic [31:0] byte_pos;
    logic [31:0] pix_offset;
    logic [31:0] img_width;
    logic [31:0] img_height;
    logic [15:0] depth;
    logic [15:0] magic;
    logic [31:0] gather;
    logic [31:0] row_byte;
    logic [31:0] file_row;
    out_item_t   due_results[$];
    int          mismatches;

    function new();
      color_key  = '0;
      mismatches = 0;
      restart_file();
    endfunction

    function void restart_file();
      phase      = DP_HEADER;
      byte_pos   = '0;
      pix_offset = '0;
      img_width  = '0;
      img_height = '0;
      depth      = '0;
      magic      = '0;
      gather     = '0;
      row_byte   = '0;
      file_row   = '0;
    endfunction

    function logic [31:0] height_mag();
      return img_height[31] ? (~img_height + 32'd1) : img_height;
    endfunction

    function void decode_byte(in_item_t item);
      logic [7:0]  b;
      logic [31:0] pos, mag, bpb, span, stride, k, col, x, y;
      logic        last;
      status_t     err;
      out_item_t   res;
      bit          have;
      b    = item.data_byte;
      pos  = byte_pos;
      res  = '0;
      have = 0;
      case (phase)
        DP_HEADER: begin
          // Little-endian header fields; other header bytes are ignored.
          if (pos <= 32'd1) magic[8*int'(pos) +: 8] = b;
          else if (pos >= POS_OFFSET && pos < POS_OFFSET + 4)
            pix_offset[8*int'(pos - POS_OFFSET) +: 8] = b;
          else if (pos >= POS_WIDTH && pos < POS_WIDTH + 4)
            img_width[8*int'(pos - POS_WIDTH) +: 8] = b;
          else if (pos >= POS_HEIGHT && pos < POS_HEIGHT + 4)
            img_height[8*int'(pos - POS_HEIGHT) +: 8] = b;
          else if (pos >= POS_DEPTH && pos < POS_DEPTH + 2)
            depth[8*int'(pos - POS_DEPTH) +: 8] = b;
          if (pos == POS_CHECK) begin
            mag = height_mag();
            err = ST_PIXEL;
            if (magic != BMP_MAGIC) err = ST_BAD_MAGIC;
            else if (depth != DEPTH_24 && depth != DEPTH_32) err = ST_BAD_DEPTH;
            else if (img_width == 0 || img_width > MAX_DIM || mag == 0 ||
                     mag > MAX_DIM || pix_offset < MIN_OFFSET) err = ST_BAD_SIZE;
            if (err != ST_PIXEL) begin
              res.status = err;
              have       = 1;
              phase      = DP_DROP;
            end else begin
              gather   = '0;
              row_byte = '0;
              file_row = '0;
              phase    = (pix_offset == MIN_OFFSET) ? DP_PIXELS : DP_SKIP;
            end
          end
        end
        DP_SKIP: begin
          if (byte_pos == pix_offset - 32'd1) phase = DP_PIXELS;
        end
        DP_PIXELS: begin
          bpb    = (depth == DEPTH_32) ? 32'd4 : 32'd3;
          span   = img_width * bpb;
          stride = ((span * 8 + 31) >> 5) << 2;
          mag    = height_mag();
          if (row_byte < span) begin
            k = row_byte % bpb;
            if (k < 3) gather = (gather | ({24'd0, b} << (8 * k))) & 32'h00FF_FFFF;
            if (k == bpb - 1) begin
              col  = (bpb == 3) ? {ALPHA_OPAQUE, gather[23:0]} : {b, gather[23:0]};
              x    = row_byte / bpb;
              y    = img_height[31] ? file_row : (mag - 32'd1 - file_row);
              last = (x == img_width - 32'd1) && (file_row == mag - 32'd1);
              if (color_key != 0 && col[23:0] == color_key) col = '0;
              res.status      = ST_PIXEL;
              res.pixel_color = col;
              res.pixel_x     = x[11:0];
              res.pixel_y     = y[11:0];
              res.last_pixel  = last;
              have            = 1;
              gather          = '0;
              if (last) phase = DP_DROP;
            end
          end
          row_byte = row_byte + 32'd1;
          if (row_byte >= stride) begin
            row_byte = '0;
            file_row = file_row + 32'd1;
            if (file_row >= mag) phase = DP_DROP;
          end
        end
        default: ;
      endcase
      byte_pos = byte_pos + 32'd1;
      // End of file before the image is done overrides any pixel of this byte.
      if (item.end_of_file) begin
        if (phase != DP_DROP) begin
          res        = '0;
          res.status = ST_SHORT;
          have       = 1;
        end
        restart_file();
      end
      if (have) due_results.push_back(res);
    endfunction

    function void report_miss(string what, out_item_t want, out_item_t got);
      mismatches++;
      if (mismatches <= REPORT_MAX) begin
        $display("%0t: %0s", $realtime, what);
        $display("  expected st=%0d col=%h x=%0d y=%0d last=%0b",
                 want.status, want.pixel_color, want.pixel_x, want.pixel_y,
                 want.last_pixel);
        $display("  got      st=%0d col=%h x=%0d y=%0d last=%0b",
                 got.status, got.pixel_color, got.pixel_x, got.pixel_y,
                 got.last_pixel);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      string     bad;
      if (due_results.size() == 0) begin
        report_miss("result with nothing expected", '0, got);
        return;
      end
      want = due_results.pop_front();
      bad  = "";
      if (got.status !== want.status)           bad = {bad, " status"};
      if (got.pixel_color !== want.pixel_color) bad = {bad, " pixel_color"};
      if (got.pixel_x !== want.pixel_x)         bad = {bad, " pixel_x"};
      if (got.pixel_y !== want.pixel_y)         bad = {bad, " pixel_y"};
      if (got.last_pixel !== want.last_pixel)   bad = {bad, " last_pixel"};
      if (bad != "") report_miss({"wrong", bad}, want, got);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block hookup. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [23:0] cfg_data  = '0;

  bmp_pixel_board board;
  logic [7:0]     file_img[$];     // file currently being built and sent
  int             bytes_taken = 0; // bytes accepted by the block so far
  int unsigned    cycle_count = 0;
  int             hold_left   = 0;
  bit             hold_done   = 0;

  bmp_stream_decoder_color_key_unit #(
    .MAX_DIM(MAX_DIM)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Sample both channels at the edge where the handshake completes. The input
  // is noted before the output is checked, so same-edge results would still
  // find their expectation.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      board.decode_byte(in_data);
      bytes_taken++;
    end
    if (rst_n && out_valid && !out_stall) board.check_result(out_data);
  end

  // Window of the run where neither side idles.
  function automatic bit quiet_span();
    return bytes_taken >= QUIET_FROM && bytes_taken < QUIET_TO;
  endfunction

  // Receiver: random stalls, plus one long hold-off while bytes keep coming,
  // so the output skid fills and the block has to stall its input.
  always @(posedge clk) begin
    if (!hold_done && bytes_taken >= HOLD_AT) begin
      hold_done = 1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (quiet_span()) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Offer one byte, with random idle cycles ahead of it; hold until taken.
  task automatic push_byte(input logic [7:0] b, input logic eof);
    while (!quiet_span() && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {b, eof};
    do @(posedge clk); while (in_stall);
  endtask

  // Send the first count bytes of the file; the last one carries end of file.
  task automatic send_bytes(input int count);
    for (int i = 0; i < count; i++) push_byte(file_img[i], i == count - 1);
  endtask

  task automatic send_file();
    send_bytes(file_img.size());
  endtask

  // Drop valid and wait until every expected result is out, plus a few cycles
  // for bytes that produce nothing.
  task automatic settle();
    in_valid <= 1'b0;
    while (board.due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the color key only with the decoder drained.
  task automatic set_key(input logic [23:0] k);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= k;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.color_key = k;
  endtask

  function automatic void put_le(input int pos, input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) file_img[pos + i] = v[8*i +: 8];
  endfunction

  // Build a BMP image into file_img: random filler header, the given fields,
  // a random gap up to the offset and padded pixel rows. Some pixels take the
  // current key so keying is exercised.
  function automatic void build_bmp(input logic [31:0] w, input logic [31:0] h,
                                    input logic [15:0] bpp, input logic [31:0] offset);
    logic [31:0] mag, bpb, stride;
    logic [23:0] rgb;
    file_img.delete();
    for (int i = 0; i <= POS_CHECK; i++) file_img.push_back(8'($urandom_range(0, 255)));
    put_le(0, 32'(BMP_MAGIC), 2);
    put_le(int'(POS_OFFSET), offset, 4);
    put_le(int'(POS_WIDTH), w, 4);
    put_le(int'(POS_HEIGHT), h, 4);
    put_le(int'(POS_DEPTH), 32'(bpp), 2);
    if (offset > MIN_OFFSET && offset <= MIN_OFFSET + 64)
      for (int i = MIN_OFFSET; i < offset; i++) file_img.push_back(8'($urandom_range(0, 255)));
    mag = h[31] ? (~h + 32'd1) : h;
    bpb = (bpp == DEPTH_32) ? 32'd4 : 32'd3;
    if (w >= 1 && w <= MAX_DIM && mag >= 1 && mag <= MAX_DIM && w * mag <= MAX_DIM) begin
      stride = ((w * bpb * 8 + 31) >> 5) << 2;
      for (int r = 0; r < mag; r++) begin
        for (int c = 0; c < w; c++) begin
          rgb = ($urandom_range(0, 3) == 0) ? board.color_key : 24'($urandom());
          file_img.push_back(rgb[7:0]);
          file_img.push_back(rgb[15:8]);
          file_img.push_back(rgb[23:16]);
          if (bpb == 4) file_img.push_back(8'($urandom_range(0, 255)));
        end
        for (int p = w * bpb; p < stride; p++) file_img.push_back(8'($urandom_range(0, 255)));
      end
    end else begin
      for (int i = 0; i < 4; i++) file_img.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  // --------------------------------------------------------------------------
  // Directed files: keying on and off, both row orders, both depths, padding,
  // every header error and every kind of early end.
  // --------------------------------------------------------------------------
  task automatic directed_files();
    // Key still at its reset value: a black pixel keeps its opaque alpha.
    build_bmp(2, 1, DEPTH_24, MIN_OFFSET);
    file_img[54] = 8'h00;
    file_img[55] = 8'h00;
    file_img[56] = 8'h00;
    send_file();
    set_key(24'hFF_FFFF);
    // Bottom-up 24 bpp with row padding and trailing junk after the image;
    // the long output hold-off lands here.
    build_bmp(3, 2, DEPTH_24, MIN_OFFSET);
    for (int i = 0; i < 3; i++) file_img.push_back(8'($urandom_range(0, 255)));
    send_file();
    // Top-down 32 bpp behind a gap before the pixel data.
    build_bmp(2, -2, DEPTH_32, 58);
    send_file();
    // Header errors.
    build_bmp(1, 1, DEPTH_24, MIN_OFFSET);
    file_img[1] = 8'h4E;
    send_file();
    build_bmp(1, 1, 16'd16, MIN_OFFSET);
    send_file();
    build_bmp(1, 1, 16'h0118, MIN_OFFSET);
    send_file();
    build_bmp(0, 1, DEPTH_24, MIN_OFFSET);
    send_file();
    build_bmp(MAX_DIM + 1, 1, DEPTH_32, MIN_OFFSET);
    send_file();
    build_bmp(1, 0, DEPTH_24, MIN_OFFSET);
    send_file();
    build_bmp(1, -(MAX_DIM + 1), DEPTH_24, MIN_OFFSET);
    send_file();
    build_bmp(1, 32'h8000_0000, DEPTH_24, MIN_OFFSET);
    send_file();
    build_bmp(1, 1, DEPTH_24, MIN_OFFSET - 1);
    send_file();
    set_key(24'h00_0001);
    // Early ends: first byte, header check byte, header error on that byte.
    build_bmp(1, 1, DEPTH_24, MIN_OFFSET);
    send_bytes(1);
    send_bytes(MIN_OFFSET);
    file_img[0] = 8'h00;
    send_bytes(MIN_OFFSET);
    // Early end inside the gap before the pixels.
    build_bmp(2, 2, DEPTH_24, 70);
    send_bytes(60);
    // Early end mid-pixel, on a completed pixel, and on the last pixel.
    build_bmp(2, 2, DEPTH_24, MIN_OFFSET);
    send_bytes(56);
    send_bytes(57);
    send_bytes(68);
    send_file();
    set_key(24'h00_0000);
  endtask

  // --------------------------------------------------------------------------
  // Random files: mostly well-formed small images with random content, mixed
  // with truncated files, corrupted headers and raw noise.
  // --------------------------------------------------------------------------
  task automatic random_files();
    int          goal, files, kind, hm;
    logic [31:0] w, h, off;
    logic [15:0] bpp;
    logic [23:0] k;
    goal  = bytes_taken + RAND_BYTES;
    files = 0;
    while (bytes_taken < goal) begin
      if (files % 5 == 4) begin
        case ($urandom_range(0, 3))
          0:       k = 24'h00_0000;
          1:       k = 24'hFF_FFFF;
          default: k = 24'($urandom());
        endcase
        set_key(k);
      end
      w    = $urandom_range(1, 6);
      hm   = $urandom_range(1, 4);
      h    = $urandom_range(0, 1) ? hm : -hm;
      bpp  = $urandom_range(0, 1) ? DEPTH_32 : DEPTH_24;
      off  = ($urandom_range(0, 2) == 0) ? MIN_OFFSET + $urandom_range(1, 10) : MIN_OFFSET;
      kind = $urandom_range(0, 99);
      build_bmp(w, h, bpp, off);
      if (kind < 65) begin
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 6)) file_img.push_back(8'($urandom_range(0, 255)));
        send_file();
      end else if (kind < 80) begin
        send_bytes($urandom_range(1, file_img.size()));
      end else if (kind < 92) begin
        case ($urandom_range(0, 6))
          0: file_img[$urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
          1: put_le(int'(POS_DEPTH), $urandom_range(0, 16'hFFFF), 2);
          2: put_le(int'(POS_WIDTH), 0, 4);
          3: put_le(int'(POS_WIDTH), $urandom_range(MAX_DIM + 1, 32'hFFFF_FFFF), 4);
          4: put_le(int'(POS_HEIGHT),
                    $urandom_range(0, 1) ? 0 : -(MAX_DIM + $urandom_range(1, 9)), 4);
          5: put_le(int'(POS_OFFSET), $urandom_range(0, MIN_OFFSET - 1), 4);
          default: put_le(int'(POS_HEIGHT), 32'h8000_0000, 4);
        endcase
        if ($urandom_range(0, 1)) send_file();
        else send_bytes($urandom_range(1, file_img.size()));
      end else begin
        file_img.delete();
        repeat ($urandom_range(1, 80)) file_img.push_back(8'($urandom_range(0, 255)));
        if (file_img.size() >= 2 && $urandom_range(0, 1)) put_le(0, 32'(BMP_MAGIC), 2);
        send_file();
      end
      files++;
    end
  endtask

  initial begin
    board = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_files();
    random_files();
    settle();
    if (board.mismatches == 0 && board.due_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/bsd_pkg.sv
hdl/bsd_hdr.sv
hdl/bsd_pix.sv
hdl/bsd_obuf.sv
hdl/bmp_stream_decoder_color_key_unit.sv
tb/sv/tb.sv
